### hdl/bgc_pkg.sv
// ----------------------------------------------------------------------------
// bgc_pkg: shared types and constants for the breadth-first graph colorer
// Graph size, field widths, sequencer states and the result beat record.
// ----------------------------------------------------------------------------
`default_nettype none

package bgc_pkg;

  localparam int NODES   = 6;
  localparam int NODE_W  = $clog2(NODES);
  localparam int COLOR_W = $clog2(NODES + 1);
  localparam int CNT_W   = $clog2(NODES + 1);

  localparam logic [NODE_W-1:0]  NODE_LAST = NODE_W'(NODES - 1);
  localparam logic [NODE_W:0]    NODE_CNT  = (NODE_W + 1)'(NODES);
  localparam logic [COLOR_W-1:0] COLOR_MAX = COLOR_W'(NODES);
  localparam logic [COLOR_W-1:0] COLOR_MIN = COLOR_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BFS_ROW,
    ST_BFS_SCAN,
    ST_COL_U,
    ST_COL_J,
    ST_RAISE,
    ST_CLASH,
    ST_EMIT
  } bgc_state_e;

  typedef struct packed {
    logic               valid;
    logic [NODE_W-1:0]  node_id;
    logic [COLOR_W-1:0] color;
    logic               last;
  } bgc_res_t;

  function automatic logic [NODES-1:0] node_bit(input logic [NODE_W-1:0] n);
    logic [NODES-1:0] r;
    r    = '0;
    r[n] = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/bgc_engine.sv
// ----------------------------------------------------------------------------
// bgc_engine: adjacency store and coloring sequencer
// Stores rows, builds the breadth-first order, colors greedily with one
// shared compare step per cycle, then offers one result per node.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_engine import bgc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_fire_i,
  input  wire logic [NODE_W-1:0]  row_node_i,
  input  wire logic [NODES-1:0]   row_bits_i,
  input  wire logic               last_row_i,
  output logic                    busy_o,
  output bgc_res_t                res_o,
  input  wire logic               res_take_i
);

  bgc_state_e state_q, state_d;

  logic [NODES-1:0]   adj_q   [NODES];
  logic [NODE_W-1:0]  order_q [NODES];
  logic [COLOR_W-1:0] color_q [NODES];

  logic [CNT_W-1:0]   head_q, head_d, tail_q, tail_d;
  logic [NODE_W-1:0]  k_q, k_d, i_q, i_d, j_q, j_d;
  logic [NODES-1:0]   visited_q, visited_d;
  logic [NODES-1:0]   row_q, row_d, rowj_q, rowj_d;
  logic [COLOR_W-1:0] cu_q, cu_d, c_q, c_d;

  logic [NODE_W-1:0]  adj_idx, col_idx, ord_idx, ord_widx;
  logic [NODES-1:0]   adj_rd;
  logic [COLOR_W-1:0] col_rd;
  logic [NODE_W-1:0]  ord_rd;
  logic               adj_we, ord_we, col_we, col_clr, adv_j;
  logic [NODE_W-1:0]  ord_wdata;

  assign adj_rd = adj_q[adj_idx];
  assign col_rd = color_q[col_idx];
  assign ord_rd = order_q[ord_idx];
  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    tail_d    = tail_q;
    k_d       = k_q;
    i_d       = i_q;
    j_d       = j_q;
    visited_d = visited_q;
    row_d     = row_q;
    rowj_d    = rowj_q;
    cu_d      = cu_q;
    c_d       = c_q;
    adj_idx   = j_q;
    col_idx   = j_q;
    ord_idx   = i_q;
    ord_widx  = tail_q[NODE_W-1:0];
    ord_wdata = k_q;
    adj_we    = 1'b0;
    ord_we    = 1'b0;
    col_we    = 1'b0;
    col_clr   = 1'b0;
    adv_j     = 1'b0;
    res_o     = '0;

    unique case (state_q)
      ST_IDLE: begin
        adj_we = in_fire_i && ({1'b0, row_node_i} < NODE_CNT);
        if (in_fire_i && last_row_i) begin
          // Seed the queue with node 0.
          ord_we    = 1'b1;
          ord_widx  = '0;
          ord_wdata = '0;
          head_d    = '0;
          tail_d    = CNT_W'(1);
          visited_d = NODES'(1);
          state_d   = ST_BFS_ROW;
        end
      end
      ST_BFS_ROW: begin
        ord_idx = head_q[NODE_W-1:0];
        adj_idx = ord_rd;
        k_d     = '0;
        if (&visited_q) begin
          i_d     = '0;
          state_d = ST_COL_U;
        end else if (head_q == tail_q) begin
          // Queue ran dry: append unreached nodes by index.
          row_d   = '1;
          state_d = ST_BFS_SCAN;
        end else begin
          row_d   = adj_rd & ~node_bit(ord_rd);
          head_d  = head_q + CNT_W'(1);
          state_d = ST_BFS_SCAN;
        end
      end
      ST_BFS_SCAN: begin
        if (row_q[k_q] && !visited_q[k_q]) begin
          visited_d[k_q] = 1'b1;
          ord_we         = 1'b1;
          tail_d         = tail_q + CNT_W'(1);
        end
        if (k_q == NODE_LAST) state_d = ST_BFS_ROW;
        else                  k_d     = k_q + NODE_W'(1);
      end
      ST_COL_U: begin
        ord_idx = i_q;
        adj_idx = ord_rd;
        col_idx = ord_rd;
        row_d   = adj_rd & ~node_bit(ord_rd);
        cu_d    = col_rd;
        j_d     = ord_rd;
        state_d = ST_COL_J;
      end
      ST_COL_J: begin
        col_idx = j_q;
        if (row_q[j_q] && (col_rd == cu_q)) state_d = ST_RAISE;
        else                                adv_j   = 1'b1;
      end
      ST_RAISE: begin
        adj_idx = j_q;
        col_idx = j_q;
        rowj_d  = adj_rd & ~node_bit(j_q);
        c_d     = (col_rd < COLOR_MAX) ? col_rd + COLOR_W'(1) : col_rd;
        k_d     = '0;
        state_d = ST_CLASH;
      end
      ST_CLASH: begin
        col_idx = k_q;
        if (c_q >= COLOR_MAX) begin
          col_we = 1'b1;
          adv_j  = 1'b1;
        end else if (rowj_q[k_q] && (col_rd == c_q)) begin
          // Clash: bump and rescan all neighbors.
          c_d = c_q + COLOR_W'(1);
          k_d = '0;
        end else if (k_q == NODE_LAST) begin
          col_we = 1'b1;
          adv_j  = 1'b1;
        end else begin
          k_d = k_q + NODE_W'(1);
        end
      end
      ST_EMIT: begin
        col_idx       = k_q;
        res_o.valid   = 1'b1;
        res_o.node_id = k_q;
        res_o.color   = col_rd;
        res_o.last    = (k_q == NODE_LAST);
        if (res_take_i) begin
          if (k_q == NODE_LAST) begin
            col_clr   = 1'b1;
            visited_d = '0;
            state_d   = ST_IDLE;
          end else begin
            k_d = k_q + NODE_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (adv_j) begin
      if (j_q == NODE_LAST) begin
        if (i_q == NODE_LAST) begin
          k_d     = '0;
          state_d = ST_EMIT;
        end else begin
          i_d     = i_q + NODE_W'(1);
          state_d = ST_COL_U;
        end
      end else begin
        j_d     = j_q + NODE_W'(1);
        state_d = ST_COL_J;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      k_q       <= '0;
      i_q       <= '0;
      j_q       <= '0;
      visited_q <= '0;
      for (int n = 0; n < NODES; n++) color_q[n] <= COLOR_MIN;
    end else begin
      head_q    <= head_d;
      tail_q    <= tail_d;
      k_q       <= k_d;
      i_q       <= i_d;
      j_q       <= j_d;
      visited_q <= visited_d;
      if (col_clr) begin
        for (int n = 0; n < NODES; n++) color_q[n] <= COLOR_MIN;
      end else if (col_we) begin
        color_q[j_q] <= c_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q  <= row_d;
    rowj_q <= rowj_d;
    cu_q   <= cu_d;
    c_q    <= c_d;
    if (adj_we) adj_q[row_node_i] <= row_bits_i;
    if (ord_we) order_q[ord_widx] <= ord_wdata;
  end

endmodule

`default_nettype wire

### hdl/bfs_greedy_graph_coloring_top.sv
// ----------------------------------------------------------------------------
// bfs_greedy_graph_coloring_top: breadth-first greedy graph colorer
//
// Input channel (in_valid_i / in_stall_o): one beat carries one adjacency
// row of a 6-node graph; row_node_i selects the row, and a row index of 6
// or 7 stores nothing. A beat with last_row_i set stores its row and then
// starts coloring; in_stall_o stays high until the last result is handed
// to the output register.
// Output channel (out_valid_o / out_stall_i): six beats, node 0 to node 5,
// each with the node's color (1..6); last_color_o marks node 5.
// Order: after the last row, the order build does one queue read and then
// a scan over all NODES nodes per dequeued node or per unreached-node
// sweep. The coloring pass reads node u's row and color, then compares
// nodes u to NODES - 1 in turn; each color raise reads the neighbor's row
// and then scans up to all NODES nodes per color tried (every compare
// reads colors through one shared read port, one neighbor per cycle).
// Results then leave one per cycle while the receiver does not stall.
// Reset clears the sequencer and sets every color to 1; adjacency rows are
// kept across graphs until rewritten. A stalled receiver holds the output
// register and the engine waits on it.
// ----------------------------------------------------------------------------
`default_nettype none

module bfs_greedy_graph_coloring_top import bgc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [NODE_W-1:0]  row_node_i,
  input  wire logic [NODES-1:0]   row_bits_i,
  input  wire logic               last_row_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [NODE_W-1:0]       node_id_o,
  output logic [COLOR_W-1:0]      color_o,
  output logic                    last_color_o
);

  bgc_res_t           res;
  logic               busy;
  logic               in_fire;
  logic               load;
  logic               out_valid_q, out_valid_d;
  logic [NODE_W-1:0]  node_id_q;
  logic [COLOR_W-1:0] color_q;
  logic               last_q;

  // Accept rows only while the sequencer is idle.
  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !in_stall_o;

  bgc_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_fire_i  (in_fire),
    .row_node_i (row_node_i),
    .row_bits_i (row_bits_i),
    .last_row_i (last_row_i),
    .busy_o     (busy),
    .res_o      (res),
    .res_take_i (load)
  );

  // Load the output register when it is empty or its beat leaves now.
  assign load = res.valid && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (load)              out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Hold the payload until the beat is taken.
  always_ff @(posedge clk_i) begin
    if (load) begin
      node_id_q <= res.node_id;
      color_q   <= res.color;
      last_q    <= res.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign node_id_o    = node_id_q;
  assign color_o      = color_q;
  assign last_color_o = last_q;

endmodule

`default_nettype wire

### hdl/bgc_checker.sv
// ----------------------------------------------------------------------------
// bgc_checker: port-level checks for the graph colorer
// Watches the top level's channels and flags broken beats or sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module bgc_checker import bgc_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic [NODE_W-1:0]  row_node_i,
  input wire logic [NODES-1:0]   row_bits_i,
  input wire logic               last_row_i,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic [NODE_W-1:0]  node_id_o,
  input wire logic [COLOR_W-1:0] color_o,
  input wire logic               last_color_o
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(node_id_o)
      && $stable(color_o) && $stable(last_color_o))
    else $error("result beat changed while stalled");

  // The last row starts coloring, so the input side must stall next.
  a_busy_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_row_i |=> in_stall_o)
    else $error("input not stalled after last row");

  // Colors stay within 1 .. NODES.
  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (color_o != '0) && (color_o <= COLOR_MAX))
    else $error("color out of range");

  // The last-node flag marks exactly the final node.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_color_o == (node_id_o == NODE_LAST)))
    else $error("last_color flag on wrong node");

endmodule

bind bfs_greedy_graph_coloring_top bgc_checker u_bgc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .row_node_i   (row_node_i),
  .row_bits_i   (row_bits_i),
  .last_row_i   (last_row_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .node_id_o    (node_id_o),
  .color_o      (color_o),
  .last_color_o (last_color_o)
);

`default_nettype wire
